// ===== src/assert_macros.svh =====
// Assertion macros for the RTL of the int8 MAC / requant / activation unit.
// Define ASSERT_OFF to compile every assertion away.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// Property holds at every clock edge outside reset.
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
		else $error(msg);

// Expression never becomes true outside reset.
`define ASSERT_NEVER(label, clk, rst_n, expr, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
		else $error(msg);

`else

`define ASSERT_CLK(label, clk, rst_n, prop, msg)
`define ASSERT_NEVER(label, clk, rst_n, expr, msg)

`endif

`endif

// ===== src/imr_pkg.sv =====
// Shared types and constants of the int8 MAC / requant / activation unit.
// No dependencies; every other RTL file refers to it by scoped names.
package imr_pkg;

	localparam int AccBits      = 32;
	localparam int TableDepth   = 256;
	localparam int TableIdxBits = $clog2(TableDepth);
	localparam int ShiftBits    = 5;

	// Request kinds carried in the mode field
	localparam logic MODE_LOAD = 1'b0;
	localparam logic MODE_MAC  = 1'b1;

	typedef struct packed {
		logic                    valid;
		logic                    mode;
		logic                    first;
		logic                    last;
		logic signed [7:0]       act;
		logic signed [7:0]       weight;
		logic signed [31:0]      bias;
		logic [TableIdxBits-1:0] index;
		logic signed [7:0]       value;
	} mac_item_t;

	// Control that follows a request down the pipeline after the MAC stage
	typedef struct packed {
		logic                    res;
		logic                    load;
		logic [TableIdxBits-1:0] index;
		logic signed [7:0]       value;
	} stage_ctl_t;

endpackage

// ===== src/imr_mac.sv =====
// Accumulator stage: bias load, 8x8 signed multiply and wrapping accumulate.
// Depends on imr_pkg.
module imr_mac (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 en,
	input  imr_pkg::mac_item_t                   item_s1,
	output imr_pkg::stage_ctl_t                  ctl_s2,
	output logic signed [imr_pkg::AccBits-1:0]   sum_s2
);

	logic signed [imr_pkg::AccBits-1:0] acc_q;
	logic signed [imr_pkg::AccBits-1:0] base;
	logic signed [imr_pkg::AccBits-1:0] acc_next;
	logic signed [15:0]                 prod;
	logic                               do_mac;

	assign do_mac   = item_s1.valid && (item_s1.mode == imr_pkg::MODE_MAC);
	assign prod     = 16'(item_s1.act) * 16'(item_s1.weight);
	assign base     = item_s1.first ? imr_pkg::AccBits'(item_s1.bias) : acc_q;
	assign acc_next = base + imr_pkg::AccBits'(prod);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q  <= '0;
			ctl_s2 <= '0;
		end else if (en) begin
			ctl_s2.res   <= do_mac && item_s1.last;
			ctl_s2.load  <= item_s1.valid && (item_s1.mode == imr_pkg::MODE_LOAD);
			ctl_s2.index <= item_s1.index;
			ctl_s2.value <= item_s1.value;
			if (do_mac) begin
				acc_q <= acc_next;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en && do_mac) begin
			sum_s2 <= acc_next;
		end
	end

endmodule

// ===== src/imr_requant.sv =====
// Requantize stage: arithmetic right shift, round half to even, saturate to int8.
// Depends on imr_pkg.
module imr_requant (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 en,
	input  logic [imr_pkg::ShiftBits-1:0]        shift_amount,
	input  imr_pkg::stage_ctl_t                  ctl_s2,
	input  logic signed [imr_pkg::AccBits-1:0]   sum_s2,
	output imr_pkg::stage_ctl_t                  ctl_s3,
	output logic signed [7:0]                    q_s3
);

	localparam int ExtBits    = imr_pkg::AccBits + (1 << imr_pkg::ShiftBits);
	localparam int ExtIdxBits = $clog2(ExtBits);

	function automatic logic signed [7:0] requant(
		input logic signed [imr_pkg::AccBits-1:0] u,
		input logic [imr_pkg::ShiftBits-1:0]      s
	);
		logic signed [ExtBits-1:0] ext;
		logic signed [ExtBits:0]   q;
		logic [ExtBits-1:0]        lowmask;
		logic                      guard;
		logic                      sticky;
		ext     = ExtBits'(u);
		q       = (ExtBits + 1)'(ext);
		guard   = 1'b0;
		sticky  = 1'b0;
		lowmask = '0;
		if (s != '0) begin
			q       = (ExtBits + 1)'(ext >>> s);
			guard   = ext[ExtIdxBits'(s - imr_pkg::ShiftBits'(1))];
			lowmask = (ExtBits'(1) << (s - imr_pkg::ShiftBits'(1))) - ExtBits'(1);
			sticky  = |(ext & lowmask);
			// round up above half, and at exactly half toward the even neighbor
			if (guard && (sticky || q[0])) begin
				q = q + (ExtBits + 1)'(1);
			end
		end
		if (q > $signed((ExtBits + 1)'(127))) begin
			requant = 8'sd127;
		end else if (q < -$signed((ExtBits + 1)'(128))) begin
			requant = -8'sd128;
		end else begin
			requant = q[7:0];
		end
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s3 <= '0;
		end else if (en) begin
			ctl_s3 <= ctl_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en && ctl_s2.res) begin
			q_s3 <= requant(sum_s2, shift_amount);
		end
	end

endmodule

// ===== src/imr_act_table.sv =====
// Activation table memory with registered read, and the result register.
// Depends on imr_pkg.
module imr_act_table (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                en,
	input  imr_pkg::stage_ctl_t ctl_s3,
	input  logic signed [7:0]   q_s3,
	output logic                out_valid_q,
	output logic signed [7:0]   activated_q,
	output logic signed [7:0]   requantized_q
);

	logic signed [7:0]                table_mem [imr_pkg::TableDepth];
	logic [imr_pkg::TableIdxBits-1:0] rd_addr;

	// requantized value plus the offset of 128 is a flip of the sign bit
	assign rd_addr = imr_pkg::TableIdxBits'(q_s3 ^ 8'h80);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (en) begin
			out_valid_q <= ctl_s3.res;
		end
	end

	always_ff @(posedge clk) begin
		if (en && ctl_s3.load) begin
			table_mem[ctl_s3.index] <= ctl_s3.value;
		end
		if (en && ctl_s3.res) begin
			activated_q   <= table_mem[rd_addr];
			requantized_q <= q_s3;
		end
	end

endmodule

// ===== src/int8_mac_requant_lut_activation_unit.sv =====
// A result reaches the master side through the request register and the MAC, requant and lookup stages, in that order.
// Throughput: one request per cycle; the whole pipeline advances whenever the result
// register is empty or being taken, so a stalled result holds every stage.
// Reset (arst_n low, asynchronous): accumulator and shift_amount cleared, pipeline empty.
// The activation table is not cleared and holds nothing meaningful until loaded.
`include "assert_macros.svh"

module int8_mac_requant_lut_activation_unit (
	input  logic        clk,
	input  logic        arst_n,
	// request stream
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	// [7:0] act, [15:8] weight, [47:16] bias, [55:48] table_index, [63:56] table_value
	input  logic [63:0] s_axis_tdata,
	// [0] mode, [1] first
	input  logic [1:0]  s_axis_tuser,
	input  logic        s_axis_tlast,
	// result stream
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// [7:0] activated, [15:8] requantized
	output logic [15:0] m_axis_tdata,
	// register port
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [1:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	localparam logic [1:0] REG_SHIFT_AMOUNT = 2'd0;

	logic [imr_pkg::ShiftBits-1:0]      shift_q;
	logic                               en;
	imr_pkg::mac_item_t                 item_s1;
	imr_pkg::stage_ctl_t                ctl_s2;
	imr_pkg::stage_ctl_t                ctl_s3;
	logic signed [imr_pkg::AccBits-1:0] sum_s2;
	logic signed [7:0]                  q_s3;
	logic signed [7:0]                  activated_q;
	logic signed [7:0]                  requantized_q;

	// register port
	assign pready = 1'b1;
	assign prdata = (paddr == REG_SHIFT_AMOUNT) ? 32'(shift_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			shift_q <= '0;
		end else if (psel && penable && pwrite && pready && paddr == REG_SHIFT_AMOUNT) begin
			shift_q <= pwdata[imr_pkg::ShiftBits-1:0];
		end
	end

	// advance every stage while the result register can move
	assign en            = !m_axis_tvalid || m_axis_tready;
	assign s_axis_tready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_s1 <= '0;
		end else if (en) begin
			item_s1.valid <= s_axis_tvalid;
			if (s_axis_tvalid) begin
				item_s1.mode   <= s_axis_tuser[0];
				item_s1.first  <= s_axis_tuser[1];
				item_s1.last   <= s_axis_tlast;
				item_s1.act    <= s_axis_tdata[7:0];
				item_s1.weight <= s_axis_tdata[15:8];
				item_s1.bias   <= s_axis_tdata[47:16];
				item_s1.index  <= s_axis_tdata[55:48];
				item_s1.value  <= s_axis_tdata[63:56];
			end
		end
	end

	imr_mac u_mac (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.item_s1 (item_s1),
		.ctl_s2  (ctl_s2),
		.sum_s2  (sum_s2)
	);

	imr_requant u_requant (
		.clk          (clk),
		.arst_n       (arst_n),
		.en           (en),
		.shift_amount (shift_q),
		.ctl_s2       (ctl_s2),
		.sum_s2       (sum_s2),
		.ctl_s3       (ctl_s3),
		.q_s3         (q_s3)
	);

	imr_act_table u_act_table (
		.clk           (clk),
		.arst_n        (arst_n),
		.en            (en),
		.ctl_s3        (ctl_s3),
		.q_s3          (q_s3),
		.out_valid_q   (m_axis_tvalid),
		.activated_q   (activated_q),
		.requantized_q (requantized_q)
	);

	assign m_axis_tdata = {requantized_q, activated_q};

	`ASSERT_CLK(a_result_from_pipe, clk, arst_n, $rose(m_axis_tvalid) |-> $past(ctl_s3.res), "result appeared without a request in the lookup stage")
	`ASSERT_NEVER(a_load_xor_result, clk, arst_n, ctl_s3.res && ctl_s3.load, "lookup stage holds both a table load and a result")
	`ASSERT_CLK(a_last_reaches_s2, clk, arst_n, (en && item_s1.valid && item_s1.mode == imr_pkg::MODE_MAC && item_s1.last) |=> ctl_s2.res, "last MAC request did not produce a pending result")

endmodule

// ===== tb/tb_int8_mac_requant_lut_activation_unit.sv =====
// Self-checking testbench for int8_mac_requant_lut_activation_unit: MAC requests,
// table loads and shift settings, with results predicted in step and checked in order.
// Depends on imr_pkg and the unit's RTL.
`timescale 1ns / 100ps

module tb_int8_mac_requant_lut_activation_unit;

	localparam logic [1:0] ADDR_SHIFT = 2'd0;
	localparam int         IDLE_PCT   = 31;
	localparam int         DRAIN_CYC  = 8;

	typedef struct {
		logic              mode;
		logic              first;
		logic              last;
		logic signed [7:0] act;
		logic signed [7:0] weight;
		logic [31:0]       bias;
		logic [7:0]        index;
		logic [7:0]        value;
	} mac_req_t;

	typedef struct {
		logic [7:0] activated;
		logic [7:0] requantized;
	} act_result_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [63:0] s_axis_tdata = '0;
	logic [1:0]  s_axis_tuser = '0;
	logic        s_axis_tlast = 1'b0;
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [15:0] m_axis_tdata;
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [1:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;

	mac_req_t          mac_requests[$];
	act_result_t       activation_results[$];
	logic signed [31:0] acc_model = '0;
	logic [7:0]        lut_model[256];
	logic [4:0]        shift_model = '0;
	logic              req_taken = 1'b0;
	logic              calm = 1'b0;
	int unsigned       queued_count = 0;
	int unsigned       taken_count = 0;
	int unsigned       error_count = 0;

	int8_mac_requant_lut_activation_unit uut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.s_axis_tlast  (s_axis_tlast),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.psel          (psel),
		.penable       (penable),
		.pwrite        (pwrite),
		.paddr         (paddr),
		.pwdata        (pwdata),
		.prdata        (prdata),
		.pready        (pready)
	);

	initial begin
		forever #10 clk = ~clk;
	end

	initial begin
		#20_000_000;
		$display("DONE: errors detected");
		$finish;
	end

	// Round half to even after the arithmetic shift, then clamp to int8.
	function automatic logic [7:0] requantize(input logic signed [31:0] sum,
			input logic [4:0] sh);
		logic signed [32:0] q;
		logic [31:0]        rem;
		logic [31:0]        half;
		if (sh == 5'd0) begin
			q = 33'(sum);
		end else begin
			q = 33'(sum >>> sh);
			rem = sum & ((32'd1 << sh) - 32'd1);
			half = 32'd1 << (sh - 5'd1);
			if (rem > half || (rem == half && q[0]))
				q = q + 33'sd1;
		end
		if (q > 127)
			return 8'sd127;
		if (q < -128)
			return -8'sd128;
		return q[7:0];
	endfunction

	task automatic advance_model(input logic [63:0] data, input logic [1:0] user,
			input logic last);
		act_result_t       res;
		logic signed [7:0] a;
		logic signed [7:0] w;
		a = data[7:0];
		w = data[15:8];
		if (user[0] == imr_pkg::MODE_LOAD) begin
			lut_model[data[55:48]] = data[63:56];
		end else begin
			if (user[1])
				acc_model = data[47:16];
			acc_model = acc_model + a * w;
			if (last) begin
				res.requantized = requantize(acc_model, shift_model);
				res.activated = lut_model[res.requantized ^ 8'h80];
				activation_results.push_back(res);
			end
		end
	endtask

	task automatic flag_mismatch(input string msg);
		$display("%0t ns: mismatch: %s", $time, msg);
		error_count++;
	endtask

	// Request side and result side, both changing at the falling edge.
	always @(negedge clk) begin
		mac_req_t r;
		if (arst_n) begin
			if (!s_axis_tvalid || req_taken) begin
				if (mac_requests.size() > 0 && (calm || $urandom_range(0, 99) >= IDLE_PCT)) begin
					r = mac_requests.pop_front();
					s_axis_tvalid <= 1'b1;
					s_axis_tdata <= {r.value, r.index, r.bias, r.weight, r.act};
					s_axis_tuser <= {r.first, r.mode};
					s_axis_tlast <= r.last;
				end else begin
					s_axis_tvalid <= 1'b0;
				end
			end
			m_axis_tready <= calm || $urandom_range(0, 99) >= IDLE_PCT;
		end
	end

	always @(posedge clk) begin
		act_result_t exp_res;
		if (arst_n) begin
			req_taken <= s_axis_tvalid && s_axis_tready;
			if (m_axis_tvalid && m_axis_tready) begin
				if (activation_results.size() == 0) begin
					flag_mismatch($sformatf("unexpected result %h", m_axis_tdata));
				end else begin
					exp_res = activation_results.pop_front();
					if (m_axis_tdata[15:8] !== exp_res.requantized)
						flag_mismatch($sformatf("requantized %h, want %h",
							m_axis_tdata[15:8], exp_res.requantized));
					if (m_axis_tdata[7:0] !== exp_res.activated)
						flag_mismatch($sformatf("activated %h, want %h",
							m_axis_tdata[7:0], exp_res.activated));
				end
			end
			if (s_axis_tvalid && s_axis_tready) begin
				taken_count <= taken_count + 1;
				advance_model(s_axis_tdata, s_axis_tuser, s_axis_tlast);
			end
		end
	end

	task automatic write_shift(input logic [4:0] sh);
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= ADDR_SHIFT;
		pwdata <= {$urandom_range(0, 1) ? 27'($urandom()) : 27'd0, sh};
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		shift_model = sh;
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	task automatic push_mac(input logic first, input logic last, input logic [7:0] a,
			input logic [7:0] w, input logic [31:0] b);
		mac_req_t r;
		r.mode = imr_pkg::MODE_MAC;
		r.first = first;
		r.last = last;
		r.act = a;
		r.weight = w;
		r.bias = b;
		r.index = 8'($urandom());
		r.value = 8'($urandom());
		mac_requests.push_back(r);
		queued_count++;
	endtask

	task automatic push_load(input logic [7:0] idx, input logic [7:0] val);
		mac_req_t r;
		r.mode = imr_pkg::MODE_LOAD;
		r.first = 1'($urandom_range(0, 1));
		r.last = 1'($urandom_range(0, 1));
		r.act = 8'($urandom());
		r.weight = 8'($urandom());
		r.bias = $urandom();
		r.index = idx;
		r.value = val;
		mac_requests.push_back(r);
		queued_count++;
	endtask

	task automatic drain_pipeline();
		@(negedge clk);
		while (taken_count != queued_count || activation_results.size() != 0)
			@(negedge clk);
		repeat (DRAIN_CYC) @(negedge clk);
	endtask

	// Bias sized near the shift most of the time so the shifted sum lands in or near int8 range.
	function automatic logic [31:0] pick_bias(input logic [4:0] sh);
		int unsigned w;
		logic [31:0] b;
		if ($urandom_range(0, 99) < 60)
			w = sh + $urandom_range(1, 10);
		else
			w = $urandom_range(1, 32);
		if (w > 32)
			w = 32;
		b = $urandom();
		if (w < 32)
			b = $signed(b << (32 - w)) >>> (32 - w);
		return b;
	endfunction

	function automatic logic [7:0] pick_byte();
		case ($urandom_range(0, 9))
			0: return 8'h80;
			1: return 8'h7f;
			default: return 8'($urandom());
		endcase
	endfunction

	task automatic add_random_items(input int unsigned n);
		int unsigned done_items;
		int unsigned len;
		int unsigned k;
		int unsigned pick;
		done_items = 0;
		while (done_items < n) begin
			pick = $urandom_range(0, 99);
			if (pick < 75) begin
				// well-formed sum: first on the opening item, last on the closing one
				len = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 40) : $urandom_range(1, 8);
				for (k = 0; k < len; k++)
					push_mac(k == 0, k == len - 1, pick_byte(), pick_byte(),
						pick_bias(shift_model));
				done_items += len;
			end else if (pick < 87) begin
				push_load(8'($urandom()), 8'($urandom()));
				done_items++;
			end else begin
				push_mac(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), pick_byte(),
					pick_byte(), pick_bias(shift_model));
				done_items++;
			end
		end
	endtask

	initial begin
		int unsigned i;
		int unsigned p;
		logic [4:0]  sh;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// reset value of the shift first, then every table entry defined
		for (i = 0; i < 256; i++)
			push_load(8'(i), 8'($urandom()));
		drain_pipeline();

		// sum from the reset accumulator, then saturation and wrap extremes
		push_mac(1'b0, 1'b0, 8'sd1, 8'sd1, 32'h0);
		push_mac(1'b0, 1'b1, -8'sd128, -8'sd128, 32'h0);
		push_mac(1'b1, 1'b1, 8'sd0, 8'sd0, 32'h0);
		push_mac(1'b1, 1'b1, 8'sd0, 8'sd5, 32'd127);
		push_mac(1'b1, 1'b1, 8'sd1, 8'sd0, 32'd128);
		push_mac(1'b1, 1'b1, 8'sd0, 8'sd0, -32'sd128);
		push_mac(1'b1, 1'b1, 8'sd0, 8'sd0, -32'sd129);
		push_mac(1'b1, 1'b1, 8'sd127, 8'sd1, 32'h7fff_ffff);
		push_mac(1'b1, 1'b1, -8'sd1, 8'sd1, 32'h8000_0000);
		push_mac(1'b1, 1'b0, -8'sd128, 8'sd127, 32'hffff_c000);
		push_mac(1'b0, 1'b0, -8'sd128, -8'sd128, 32'hffff_ffff);
		push_mac(1'b0, 1'b1, 8'sd127, -8'sd128, 32'h1234_5678);
		// load between items leaves the accumulator alone
		push_mac(1'b1, 1'b0, 8'sd3, 8'sd4, -32'sd20);
		push_load(8'd128, 8'h5a);
		push_mac(1'b0, 1'b1, 8'sd0, 8'sd0, 32'h0);
		drain_pipeline();

		write_shift(5'd1);
		push_mac(1'b1, 1'b1, 8'sd0, 8'sd0, 32'd1);
		push_mac(1'b1, 1'b1, 8'sd0, 8'sd0, 32'd3);
		push_mac(1'b1, 1'b1, 8'sd0, 8'sd0, -32'sd1);
		push_mac(1'b1, 1'b1, 8'sd0, 8'sd0, -32'sd3);
		push_mac(1'b1, 1'b1, 8'sd0, 8'sd0, 32'd5);
		drain_pipeline();

		write_shift(5'd31);
		push_mac(1'b1, 1'b1, 8'sd0, 8'sd0, 32'h8000_0000);
		push_mac(1'b1, 1'b1, 8'sd0, 8'sd0, 32'h4000_0000);
		push_mac(1'b1, 1'b1, 8'sd1, 8'sd1, 32'h4000_0000);
		push_mac(1'b1, 1'b1, 8'sd0, 8'sd0, 32'h7fff_ffff);
		push_mac(1'b1, 1'b1, 8'sd0, 8'sd0, 32'hc000_0000);
		push_mac(1'b1, 1'b1, -8'sd1, 8'sd1, 32'hc000_0000);
		drain_pipeline();

		for (p = 0; p < 6; p++) begin
			case (p)
				0: sh = 5'd4;
				1: sh = 5'd31;
				3: sh = 5'd0;
				5: sh = 5'd12;
				default: sh = 5'($urandom_range(1, 30));
			endcase
			write_shift(sh);
			calm = (p == 2);
			add_random_items(228);
			drain_pipeline();
			calm = 1'b0;
		end

		if (error_count == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule
